>>> hw/rtl/igm_pkg.sv
// ----------------------------------------------------------------------------
// igm_pkg
// shared widths, codes and the queue record of the interval gap merge block
// ----------------------------------------------------------------------------
package igm_pkg;

    localparam int REF_W       = 16;
    localparam int POS_W       = 32;
    localparam int CNT_W       = 32;
    localparam int GAP_W       = 20;
    localparam int FRAC_BITS   = 16;
    localparam int WIN_W       = POS_W + 1;
    localparam int DENS_W      = CNT_W + FRAC_BITS;
    localparam int DIV_STEPS   = DENS_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int REM_W       = WIN_W + 1;

    localparam int IN_FIELDS_W = REF_W + 2 * POS_W + CNT_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = REF_W + 2 * POS_W + WIN_W + CNT_W + DENS_W;
    localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(4);

    typedef enum logic {
        ACT_RECORD = 1'b0,
        ACT_FLUSH  = 1'b1
    } t_action;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [POS_W-1:0] end_pos;
        logic [POS_W-1:0] begin_pos;
        logic [REF_W-1:0] ref_id;
    } t_emit;

    typedef struct packed {
        logic  valid;
        t_emit data;
    } t_queue_head;

endpackage

>>> hw/rtl/interval_gap_merge.sv
// ----------------------------------------------------------------------------
// interval_gap_merge
// merges a sorted stream of intervals whose start gap is below merge_gap and
// emits each merged interval with window size, count total and Q32.16 density
// ----------------------------------------------------------------------------
// throughput: one input transfer per cycle while the two-entry queue has room;
//   the back part works on one emitted interval at a time, through the bit-serial
//   density divider, which a bad window skips
// reset: synchronous, active low; clears the pending interval and the queue,
//   merge_gap returns to 4
// ----------------------------------------------------------------------------
module interval_gap_merge (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [igm_pkg::GAP_W-1:0]        i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // ref_id, begin_pos, end_pos, n_value
    input  logic [igm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // action
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_ref_id, out_begin, out_end, window_size, n_total, density, zero pad
    output logic [igm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // bad_window
    output logic                             m_axis_tuser
);
    import igm_pkg::*;

    t_emit        w_rec;
    logic         w_queue_full;
    logic         w_push;
    t_emit        w_push_data;
    logic         w_pop;
    t_queue_head  w_head;

    assign w_rec = t_emit'(s_axis_tdata[IN_FIELDS_W-1:0]);

    igm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_action     (s_axis_tuser),
        .i_rec        (w_rec),
        .i_queue_full (w_queue_full),
        .o_push       (w_push),
        .o_push_data  (w_push_data)
    );

    igm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_queue_full),
        .i_pop       (w_pop),
        .o_head      (w_head)
    );

    igm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_bad   (m_axis_tuser)
    );

endmodule

>>> hw/rtl/igm_front.sv
// ----------------------------------------------------------------------------
// igm_front
// accepts interval transfers, holds the pending merged interval and decides
// join or emit; emitted intervals are pushed into the queue
// ----------------------------------------------------------------------------
module igm_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [igm_pkg::GAP_W-1:0]   i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_action,
    input  igm_pkg::t_emit              i_rec,
    input  logic                        i_queue_full,
    output logic                        o_push,
    output igm_pkg::t_emit              o_push_data
);
    import igm_pkg::*;

    logic                 r_pend_valid;
    t_emit                r_pend;
    logic [GAP_W-1:0]     r_merge_gap;

    logic                 w_accept;
    logic [POS_W+1:0]     w_limit;
    logic                 w_join;
    logic [CNT_W:0]       w_sum;
    logic [CNT_W-1:0]     w_sat;

    assign o_ready  = !i_queue_full;
    assign w_accept = i_valid && o_ready;

    // gap = begin - (end + 1) < merge_gap  <=>  begin < end + 1 + merge_gap
    assign w_limit = {2'b00, r_pend.end_pos} + (POS_W+2)'(1)
                   + (POS_W+2)'(r_merge_gap);
    assign w_join  = (i_rec.ref_id == r_pend.ref_id)
                   && ({2'b00, i_rec.begin_pos} < w_limit);

    assign w_sum = {1'b0, r_pend.count} + {1'b0, i_rec.count};
    assign w_sat = w_sum[CNT_W] ? {CNT_W{1'b1}} : w_sum[CNT_W-1:0];

    assign o_push_data = r_pend;
    assign o_push      = w_accept && r_pend_valid
                       && ((t_action'(i_action) == ACT_FLUSH) || !w_join);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_merge_gap  <= GAP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_merge_gap <= i_cfg_wdata;
            end
            if (w_accept) begin
                if (t_action'(i_action) == ACT_FLUSH) begin
                    r_pend_valid <= 1'b0;
                end else if (r_pend_valid && w_join) begin
                    r_pend.end_pos <= i_rec.end_pos;
                    r_pend.count   <= w_sat;
                end else begin
                    r_pend_valid <= 1'b1;
                    r_pend       <= i_rec;
                end
            end
        end
    end

endmodule

>>> hw/rtl/igm_queue.sv
// ----------------------------------------------------------------------------
// igm_queue
// short queue of emitted intervals between the front and the back part
// ----------------------------------------------------------------------------
module igm_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  igm_pkg::t_emit        i_push_data,
    output logic                  o_full,
    input  logic                  i_pop,
    output igm_pkg::t_queue_head  o_head
);
    import igm_pkg::*;

    t_emit                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr;
    logic [QUEUE_CW-1:0]  r_count;

    logic                 w_push;
    logic                 w_pop;

    assign o_full      = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.data  = r_mem[r_rd_ptr];

    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                     : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hw/rtl/igm_back.sv
// ----------------------------------------------------------------------------
// igm_back
// takes emitted intervals from the queue, works out window size and density
// with a bit-serial restoring divider and drives the result register
// ----------------------------------------------------------------------------
module igm_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  igm_pkg::t_queue_head             i_head,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [igm_pkg::OUT_TDATA_W-1:0]  o_data,
    output logic                             o_bad
);
    import igm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } t_state;

    t_state                r_state;
    t_emit                 r_item;
    logic [WIN_W-1:0]      r_win;
    logic                  r_bad;
    logic [REM_W-1:0]      r_rem;
    logic [DENS_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                  r_out_bad;

    logic                  w_bad;
    logic [WIN_W-1:0]      w_win;
    logic [REM_W-1:0]      w_shift;
    logic [REM_W-1:0]      w_trial;
    logic                  w_fits;
    logic                  w_load_out;

    assign w_bad = (i_head.data.end_pos < i_head.data.begin_pos);
    assign w_win = {1'b0, i_head.data.end_pos} + WIN_W'(1) - {1'b0, i_head.data.begin_pos};

    // one quotient bit per cycle
    assign w_shift = {r_rem[REM_W-2:0], r_quo[DENS_W-1]};
    assign w_trial = w_shift - {1'b0, r_win};
    assign w_fits  = (w_shift >= {1'b0, r_win});

    assign o_pop      = (r_state == S_IDLE) && i_head.valid;
    assign w_load_out = (r_state == S_HOLD) && (!r_out_valid || i_ready);

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_bad   = r_out_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && !w_load_out) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_item <= i_head.data;
                        r_bad  <= w_bad;
                        r_rem  <= '0;
                        r_cnt  <= '0;
                        if (w_bad) begin
                            r_win   <= '0;
                            r_quo   <= '0;
                            r_state <= S_HOLD;
                        end else begin
                            r_win   <= w_win;
                            r_quo   <= {i_head.data.count, {FRAC_BITS{1'b0}}};
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= w_fits ? w_trial : w_shift;
                    r_quo <= {r_quo[DENS_W-2:0], w_fits};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (w_load_out) begin
                        r_out_valid <= 1'b1;
                        r_out_bad   <= r_bad;
                        r_out_data  <= OUT_TDATA_W'({r_quo, r_item.count, r_win,
                                                     r_item.end_pos, r_item.begin_pos,
                                                     r_item.ref_id});
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
